// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file of the heap queue.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define IMH_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define IMH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/imh_pkg.sv =====
// Shared constants and codes of the indexed min-heap queue.
// Depends on nothing; used by the interfaces, the top level and the checker.
package imh_pkg;

    localparam int CMD_BITS     = 2;
    localparam int ID_BITS      = 10;
    localparam int ID_COUNT     = 1024;
    localparam int KEY_IO_BITS  = 32;
    localparam int STATUS_BITS  = 2;
    localparam int CAPACITY_DEF = 1024;
    localparam int KEY_BITS_DEF = 32;

    localparam logic [CMD_BITS-1:0] CMD_INSERT   = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_POP      = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_DECREASE = 2'd2;

    localparam logic [STATUS_BITS-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_EMPTY   = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_FULL    = 2'd2;
    localparam logic [STATUS_BITS-1:0] ST_UNKNOWN = 2'd3;

endpackage

// ===== rtl/imh_req_if.sv =====
// Request channel of the heap queue: valid/ready handshake and command payload.
// Depends on imh_pkg.
interface imh_req_if;
    import imh_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [CMD_BITS-1:0]    cmd;
    logic [ID_BITS-1:0]     item_id;
    logic [KEY_IO_BITS-1:0] new_key;

    modport source (output valid, output cmd, output item_id, output new_key, input ready);
    modport sink   (input valid, input cmd, input item_id, input new_key, output ready);
endinterface

// ===== rtl/imh_rsp_if.sv =====
// Response channel of the heap queue: valid/ready handshake and result payload.
// Depends on imh_pkg.
interface imh_rsp_if;
    import imh_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [ID_BITS-1:0]     out_id;
    logic [KEY_IO_BITS-1:0] out_key;
    logic                   out_valid;
    logic [STATUS_BITS-1:0] status;

    modport source (output valid, output out_id, output out_key, output out_valid,
                    output status, input ready);
    modport sink   (input valid, input out_id, input out_key, input out_valid,
                    input status, output ready);
endinterface

// ===== rtl/imh_heap_ram.sv =====
// Heap slot storage: one write port, two registered read ports.
// Depends on imh_pkg for default sizes.
module imh_heap_ram #(
    parameter int DEPTH = imh_pkg::CAPACITY_DEF,
    parameter int DW    = imh_pkg::ID_BITS + imh_pkg::KEY_BITS_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr_a,
    input  logic [AW-1:0] raddr_b,
    output logic [DW-1:0] rdata_a,
    output logic [DW-1:0] rdata_b
);
    import imh_pkg::*;

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end
endmodule

// ===== rtl/imh_map_ram.sv =====
// Id-to-slot map storage: one write port, one registered read port.
// Depends on imh_pkg for the id space.
module imh_map_ram #(
    parameter int SW = 11
) (
    input  logic                        clk,
    input  logic                        we,
    input  logic [imh_pkg::ID_BITS-1:0] waddr,
    input  logic [SW-1:0]               wdata,
    input  logic [imh_pkg::ID_BITS-1:0] raddr,
    output logic [SW-1:0]               rdata
);
    import imh_pkg::*;

    logic [SW-1:0] mem [ID_COUNT];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== rtl/indexed_min_heap_queue_top.sv =====
// Indexed min-heap queue: insert, pop minimum and decrease-key on item ids.
// A full insert, an empty pop or cmd 3 goes straight from idle to the done state; a duplicate
// insert, an unknown id or a pop of the last entry ends after one map or heap read; a decrease to
// a larger key ends after the map and key reads; other commands walk the heap level by level,
// each level a read state and an evaluate state. One transaction is in work at a time.
// Reset: the id map's ID_COUNT (1024) entries are swept to zero with req.ready low.
module indexed_min_heap_queue_top #(
    parameter int CAPACITY = imh_pkg::CAPACITY_DEF,
    parameter int KEY_BITS = imh_pkg::KEY_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    imh_req_if.sink    req,
    imh_rsp_if.source  rsp
);
    import imh_pkg::*;

    // Slot numbers run from 1 to CAPACITY; zero in the map means absent.
    localparam int SW = $clog2(CAPACITY + 1);
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    localparam logic [3:0] S_CLR     = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_INS_CHK = 4'd2;
    localparam logic [3:0] S_DK_MAP  = 4'd3;
    localparam logic [3:0] S_DK_KEY  = 4'd4;
    localparam logic [3:0] S_POP_RD  = 4'd5;
    localparam logic [3:0] S_SU_RD   = 4'd6;
    localparam logic [3:0] S_SU_EV   = 4'd7;
    localparam logic [3:0] S_SD_RD   = 4'd8;
    localparam logic [3:0] S_SD_EV   = 4'd9;
    localparam logic [3:0] S_PLACE   = 4'd10;
    localparam logic [3:0] S_DONE    = 4'd11;

    typedef struct packed {
        logic [ID_BITS-1:0]  id;
        logic [KEY_BITS-1:0] key;
    } entry_t;

    logic [3:0]             state_reg, state_next;
    logic [SW-1:0]          cnt_reg, cnt_next;
    logic [SW-1:0]          slot_reg, slot_next;
    logic [ID_BITS-1:0]     clr_reg, clr_next;
    entry_t                 cur_reg, cur_next;

    // Result being built for the current transaction.
    logic [ID_BITS-1:0]     wid_reg, wid_next;
    logic [KEY_BITS-1:0]    wkey_reg, wkey_next;
    logic                   wval_reg, wval_next;
    logic [STATUS_BITS-1:0] wst_reg, wst_next;

    // Output register, which parts the response side from the heap engine.
    logic                   ov_reg;
    logic [ID_BITS-1:0]     oid_reg;
    logic [KEY_IO_BITS-1:0] okey_reg;
    logic                   oval_reg;
    logic [STATUS_BITS-1:0] ost_reg;
    logic                   out_load;

    logic                   h_we;
    logic [AW-1:0]          h_waddr, h_ra, h_rb;
    entry_t                 h_wdata, h_qa, h_qb;
    logic                   m_we;
    logic [ID_BITS-1:0]     m_waddr, m_ra;
    logic [SW-1:0]          m_wdata, m_q;

    logic [SW:0]            l_slot, r_slot;
    logic [KEY_BITS-1:0]    best_key;
    logic                   pick_l, pick_r;

    imh_heap_ram #(
        .DEPTH (CAPACITY),
        .DW    (ID_BITS + KEY_BITS)
    ) u_heap (
        .clk     (clk),
        .we      (h_we),
        .waddr   (h_waddr),
        .wdata   (h_wdata),
        .raddr_a (h_ra),
        .raddr_b (h_rb),
        .rdata_a (h_qa),
        .rdata_b (h_qb)
    );

    imh_map_ram #(
        .SW (SW)
    ) u_map (
        .clk   (clk),
        .we    (m_we),
        .waddr (m_waddr),
        .wdata (m_wdata),
        .raddr (m_ra),
        .rdata (m_q)
    );

    assign l_slot = {slot_reg, 1'b0};
    assign r_slot = l_slot + 1'b1;

    // Sift-down choice: the left child wins ties against the right one, and a
    // child moves up only on a strictly smaller key.
    assign pick_l   = h_qa.key < cur_reg.key;
    assign best_key = pick_l ? h_qa.key : cur_reg.key;
    assign pick_r   = (r_slot <= {1'b0, cnt_reg}) && (h_qb.key < best_key);

    // The engine walks the heap with a hole: the moving entry stays in cur_reg
    // and is written only once it settles, while each entry passed over is
    // moved one level and has its map entry rewritten. Every read is issued in
    // one state and used in the next, after all earlier writes have landed, so
    // reads and writes never meet on the same entry in one cycle.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        slot_next  = slot_reg;
        clr_next   = clr_reg;
        cur_next   = cur_reg;
        wid_next   = wid_reg;
        wkey_next  = wkey_reg;
        wval_next  = wval_reg;
        wst_next   = wst_reg;
        h_we       = 1'b0;
        h_waddr    = AW'(slot_reg - 1'b1);
        h_wdata    = cur_reg;
        h_ra       = '0;
        h_rb       = '0;
        m_we       = 1'b0;
        m_waddr    = cur_reg.id;
        m_wdata    = slot_reg;
        m_ra       = req.item_id;
        case (state_reg)
            S_CLR:
            begin
                m_we     = 1'b1;
                m_waddr  = clr_reg;
                m_wdata  = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == ID_BITS'(ID_COUNT - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                // Root and last slot are read at once for a pop.
                h_ra = '0;
                h_rb = AW'(cnt_reg - 1'b1);
                if (req.valid)
                begin
                    cur_next.id  = req.item_id;
                    cur_next.key = KEY_BITS'(req.new_key);
                    wid_next     = '0;
                    wkey_next    = '0;
                    wval_next    = 1'b0;
                    wst_next     = ST_OK;
                    case (req.cmd)
                        CMD_INSERT:
                        begin
                            if (cnt_reg == SW'(CAPACITY))
                            begin
                                wst_next   = ST_FULL;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                state_next = S_INS_CHK;
                            end
                        end
                        CMD_POP:
                        begin
                            if (cnt_reg == '0)
                            begin
                                wst_next   = ST_EMPTY;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                state_next = S_POP_RD;
                            end
                        end
                        CMD_DECREASE:
                        begin
                            state_next = S_DK_MAP;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_INS_CHK:
            begin
                // An id already present makes the insert a no-op.
                if (m_q != '0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cnt_next   = cnt_reg + 1'b1;
                    slot_next  = cnt_reg + 1'b1;
                    state_next = S_SU_RD;
                end
            end
            S_DK_MAP:
            begin
                slot_next = m_q;
                h_ra      = AW'(m_q - 1'b1);
                if (m_q == '0 || m_q > cnt_reg)
                begin
                    wst_next   = ST_UNKNOWN;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_DK_KEY;
                end
            end
            S_DK_KEY:
            begin
                // A larger key leaves the entry as it was.
                if (cur_reg.key <= h_qa.key)
                begin
                    state_next = S_SU_RD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_POP_RD:
            begin
                wid_next  = h_qa.id;
                wkey_next = h_qa.key;
                wval_next = 1'b1;
                m_we      = 1'b1;
                m_waddr   = h_qa.id;
                m_wdata   = '0;
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg > SW'(1))
                begin
                    cur_next   = h_qb;
                    slot_next  = SW'(1);
                    state_next = S_SD_RD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_SU_RD:
            begin
                h_ra = AW'((slot_reg >> 1) - 1'b1);
                if (slot_reg == SW'(1))
                begin
                    state_next = S_PLACE;
                end
                else
                begin
                    state_next = S_SU_EV;
                end
            end
            S_SU_EV:
            begin
                if (h_qa.key > cur_reg.key)
                begin
                    h_we       = 1'b1;
                    h_wdata    = h_qa;
                    m_we       = 1'b1;
                    m_waddr    = h_qa.id;
                    slot_next  = slot_reg >> 1;
                    state_next = S_SU_RD;
                end
                else
                begin
                    state_next = S_PLACE;
                end
            end
            S_SD_RD:
            begin
                h_ra = AW'(l_slot - 1'b1);
                h_rb = AW'(l_slot);
                if (l_slot > {1'b0, cnt_reg})
                begin
                    state_next = S_PLACE;
                end
                else
                begin
                    state_next = S_SD_EV;
                end
            end
            S_SD_EV:
            begin
                if (pick_r)
                begin
                    h_we       = 1'b1;
                    h_wdata    = h_qb;
                    m_we       = 1'b1;
                    m_waddr    = h_qb.id;
                    slot_next  = SW'(r_slot);
                    state_next = S_SD_RD;
                end
                else if (pick_l)
                begin
                    h_we       = 1'b1;
                    h_wdata    = h_qa;
                    m_we       = 1'b1;
                    m_waddr    = h_qa.id;
                    slot_next  = SW'(l_slot);
                    state_next = S_SD_RD;
                end
                else
                begin
                    state_next = S_PLACE;
                end
            end
            S_PLACE:
            begin
                h_we       = 1'b1;
                m_we       = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!ov_reg || rsp.ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_load = (state_reg == S_DONE) && (!ov_reg || rsp.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            cnt_reg   <= '0;
            clr_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            clr_reg   <= clr_next;
            if (out_load)
            begin
                ov_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
        cur_reg  <= cur_next;
        wid_reg  <= wid_next;
        wkey_reg <= wkey_next;
        wval_reg <= wval_next;
        wst_reg  <= wst_next;
        if (out_load)
        begin
            oid_reg  <= wid_reg;
            okey_reg <= KEY_IO_BITS'(wkey_reg);
            oval_reg <= wval_reg;
            ost_reg  <= wst_reg;
        end
    end

    assign req.ready     = (state_reg == S_IDLE);
    assign rsp.valid     = ov_reg;
    assign rsp.out_id    = oid_reg;
    assign rsp.out_key   = okey_reg;
    assign rsp.out_valid = oval_reg;
    assign rsp.status    = ost_reg;
endmodule

// ===== rtl/imh_checker.sv =====
// Port-level checks of the heap queue, bound to the top level.
// Depends on imh_pkg, assert_macros.svh and indexed_min_heap_queue_top.
`include "assert_macros.svh"

module imh_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            req_valid,
    input logic                            req_ready,
    input logic                            rsp_valid,
    input logic                            rsp_ready,
    input logic [imh_pkg::ID_BITS-1:0]     rsp_out_id,
    input logic [imh_pkg::KEY_IO_BITS-1:0] rsp_out_key,
    input logic                            rsp_out_valid,
    input logic [imh_pkg::STATUS_BITS-1:0] rsp_status
);
    import imh_pkg::*;

    // A stalled response keeps its payload.
    `IMH_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_out_id) && $stable(rsp_out_key) && $stable(rsp_status) && $stable(rsp_out_valid), "response changed while stalled")

    // A returned item always comes with a good status.
    `IMH_ASSERT_NOW(a_pop_ok, clk, rst_n, rsp_valid && rsp_out_valid, rsp_status == ST_OK, "popped item with error status")

    // Without a returned item the id and key read as zero.
    `IMH_ASSERT_NOW(a_no_item_zero, clk, rst_n, rsp_valid && !rsp_out_valid, rsp_out_id == '0 && rsp_out_key == '0, "nonzero payload without item")

    // Only one transaction is in work, so ready drops after each accept.
    `IMH_ASSERT_NEXT(a_one_in_work, clk, rst_n, req_valid && req_ready, !req_ready, "request taken while busy")
endmodule

bind indexed_min_heap_queue_top imh_checker u_imh_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .rsp_out_id    (rsp.out_id),
    .rsp_out_key   (rsp.out_key),
    .rsp_out_valid (rsp.out_valid),
    .rsp_status    (rsp.status)
);
